// ----- rtl/rmq_pkg.sv -----
// shared widths and sideband types for the rotation matrix to quaternion pipeline
package rmq_pkg;

    localparam int ElemW  = 16;   // input element, signed q2.14
    localparam int VecW   = 18;   // signed unnormalized component
    localparam int AbsW   = 17;   // magnitude of a component
    localparam int SqW    = 2 * AbsW;
    localparam int NW     = SqW + 2;  // sum of four squares
    localparam int RadW   = 64;   // sqrt radicand, n shifted up by 28
    localparam int RadSh  = RadW - NW;
    localparam int RootW  = RadW / 2;
    localparam int RemW   = RootW + 2;
    localparam int QW     = 16;   // quotient and output width
    localparam int NumW   = AbsW + 28 + 1;
    localparam int Lanes  = 4;
    localparam logic signed [VecW-1:0] FixOne = VecW'(16384);

    // per-beat sideband carried beside the datapath
    typedef struct packed {
        logic [Lanes-1:0][AbsW-1:0] amag;
        logic [Lanes-1:0]           neg;
        logic                       deg;
    } side_t;

    typedef struct packed {
        logic [Lanes-1:0] neg;
        logic             deg;
    } tag_t;

endpackage

// ----- rtl/rmq_isqrt.sv -----
// pipelined integer square root, one result bit per stage, with sideband
module rmq_isqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rmq_pkg::RadW-1:0]   rad,
    input  rmq_pkg::side_t             side_in,
    output logic [rmq_pkg::RootW-1:0]  root,
    output rmq_pkg::side_t             side_out
);
    import rmq_pkg::*;

    logic [RemW-1:0]  rem_reg  [RootW];
    logic [RootW-1:0] root_reg [RootW];
    logic [RadW-1:0]  x_reg    [RootW];
    side_t            side_reg [RootW];

    for (genvar i = 0; i < RootW; i++) begin : g_stage
        logic [RemW-1:0]  rem_cur;
        logic [RootW-1:0] root_cur;
        logic [RadW-1:0]  x_cur;
        side_t            side_cur;
        logic [RemW+1:0]  shifted;
        logic [RemW+1:0]  trial;

        if (i == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign x_cur    = rad;
            assign side_cur = side_in;
        end else begin : g_rest
            assign rem_cur  = rem_reg[i-1];
            assign root_cur = root_reg[i-1];
            assign x_cur    = x_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        assign shifted = {rem_cur, x_cur[RadW-1 -: 2]};
        assign trial   = shifted - {2'b00, root_cur, 2'b01};

        always_ff @(posedge clk) begin
            if (en) begin
                if (shifted >= {2'b00, root_cur, 2'b01}) begin
                    rem_reg[i]  <= trial[RemW-1:0];
                    root_reg[i] <= {root_cur[RootW-2:0], 1'b1};
                end else begin
                    rem_reg[i]  <= shifted[RemW-1:0];
                    root_reg[i] <= {root_cur[RootW-2:0], 1'b0};
                end
                x_reg[i]    <= {x_cur[RadW-3:0], 2'b00};
                side_reg[i] <= side_cur;
            end
        end
    end

    assign root     = root_reg[RootW-1];
    assign side_out = side_reg[RootW-1];

endmodule

// ----- rtl/rmq_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module rmq_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rmq_pkg::NumW-1:0]   num,
    input  logic [rmq_pkg::RootW-1:0]  den,
    output logic [rmq_pkg::QW-1:0]     quo
);
    import rmq_pkg::*;

    logic [RootW-1:0] rem_reg [QW];
    logic [QW-1:0]    low_reg [QW];
    logic [QW-1:0]    q_reg   [QW];
    logic [RootW-1:0] den_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [RootW-1:0] rem_cur;
        logic [QW-1:0]    low_cur;
        logic [QW-1:0]    q_cur;
        logic [RootW-1:0] den_cur;
        logic [RootW:0]   t;

        if (j == 0) begin : g_first
            // upper part of the numerator is already below the divisor
            assign rem_cur = RootW'(num[NumW-1:QW]);
            assign low_cur = num[QW-1:0];
            assign q_cur   = '0;
            assign den_cur = den;
        end else begin : g_rest
            assign rem_cur = rem_reg[j-1];
            assign low_cur = low_reg[j-1];
            assign q_cur   = q_reg[j-1];
            assign den_cur = den_reg[j-1];
        end

        assign t = {rem_cur, low_cur[QW-1]};

        always_ff @(posedge clk) begin
            if (en) begin
                if (t >= {1'b0, den_cur}) begin
                    rem_reg[j] <= RootW'(t - {1'b0, den_cur});
                    q_reg[j]   <= {q_cur[QW-2:0], 1'b1};
                end else begin
                    rem_reg[j] <= t[RootW-1:0];
                    q_reg[j]   <= {q_cur[QW-2:0], 1'b0};
                end
                low_reg[j] <= {low_cur[QW-2:0], 1'b0};
                den_reg[j] <= den_cur;
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// top level: rotation matrix to unit quaternion, fully pipelined
// converts a 3x3 rotation matrix in signed q2.14 to a normalized quaternion
// (shepperd's method). one beat is taken every cycle while the output side
// keeps taking beats (53 register stages, the first loaded by the accepting
// edge). the pipeline depth is set by the square root (one result bit per
// stage, 32 stages) and the four parallel dividers (one quotient bit per
// stage, 16 stages), plus branch select, squaring, sum, divider setup and
// output stages. a stall on the output freezes the whole pipeline; nothing is
// lost.
// degenerate is raised, with all components zero, when the pivot radicand of
// the x, y or z branch is not positive.
module rotation_matrix_to_quaternion_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [15:0]         e00,
    input  logic signed [15:0]         e01,
    input  logic signed [15:0]         e02,
    input  logic signed [15:0]         e10,
    input  logic signed [15:0]         e11,
    input  logic signed [15:0]         e12,
    input  logic signed [15:0]         e20,
    input  logic signed [15:0]         e21,
    input  logic signed [15:0]         e22,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [15:0]         qx,
    output logic signed [15:0]         qy,
    output logic signed [15:0]         qz,
    output logic signed [15:0]         qw
    ,
    output logic                       degenerate
);
    import rmq_pkg::*;

    // stages: select, square, sum, sqrt, divider setup, divide, output
    localparam int NStg = 3 + RootW + 1 + QW + 1;

    logic            en;
    logic [NStg-1:0] vld_reg;

    // whole pipeline advances unless the output beat is stuck
    assign en       = !vld_reg[NStg-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NStg-2:0], in_valid};
        end
    end

    // ---- stage 1: branch select and unnormalized vector ----
    logic signed [VecW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [VecW-1:0] trace;
    logic signed [VecW-1:0] vx_c, vy_c, vz_c, vw_c, r_c;
    logic signed [VecW-1:0] v_reg [Lanes];
    logic                   deg1_reg;

    assign m00 = VecW'(e00);
    assign m01 = VecW'(e01);
    assign m02 = VecW'(e02);
    assign m10 = VecW'(e10);
    assign m11 = VecW'(e11);
    assign m12 = VecW'(e12);
    assign m20 = VecW'(e20);
    assign m21 = VecW'(e21);
    assign m22 = VecW'(e22);
    assign trace = m00 + m11 + m22;

    always_comb begin
        if (trace > 0) begin
            // w pivot
            r_c  = trace + FixOne;
            vw_c = r_c;
            vx_c = m21 - m12;
            vy_c = m02 - m20;
            vz_c = m10 - m01;
        end else if (m00 > m11 && m00 > m22) begin
            r_c  = FixOne + m00 - m11 - m22;
            vw_c = m21 - m12;
            vx_c = r_c;
            vy_c = m01 + m10;
            vz_c = m02 + m20;
        end else if (m11 > m22) begin
            r_c  = FixOne + m11 - m00 - m22;
            vw_c = m02 - m20;
            vx_c = m01 + m10;
            vy_c = r_c;
            vz_c = m12 + m21;
        end else begin
            // ties against m22 land here; an m00/m11 tie above m22 takes the y branch
            r_c  = FixOne + m22 - m00 - m11;
            vw_c = m10 - m01;
            vx_c = m02 + m20;
            vy_c = m12 + m21;
            vz_c = r_c;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            v_reg[0] <= vx_c;
            v_reg[1] <= vy_c;
            v_reg[2] <= vz_c;
            v_reg[3] <= vw_c;
            deg1_reg <= (r_c <= 0);
        end
    end

    // ---- stage 2: magnitudes and squares ----
    logic [SqW-1:0] sq_reg [Lanes];
    side_t          side2_reg;
    side_t          side2_c;
    logic [AbsW-1:0] amag_c [Lanes];

    always_comb begin
        side2_c.deg = deg1_reg;
        for (int k = 0; k < Lanes; k++) begin
            amag_c[k]       = v_reg[k][VecW-1] ? AbsW'(-v_reg[k]) : AbsW'(v_reg[k]);
            side2_c.amag[k] = amag_c[k];
            side2_c.neg[k]  = v_reg[k][VecW-1];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < Lanes; k++) begin
                sq_reg[k] <= amag_c[k] * amag_c[k];
            end
            side2_reg <= side2_c;
        end
    end

    // ---- stage 3: sum of squares ----
    logic [NW-1:0] n_reg;
    side_t         side3_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            n_reg     <= NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]) + NW'(sq_reg[3]);
            side3_reg <= side2_reg;
        end
    end

    // ---- square root: magnitude in q.28 ----
    logic [RootW-1:0] mag;
    side_t            side_sq;

    rmq_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .rad      ({n_reg, RadSh'(0)}),
        .side_in  (side3_reg),
        .root     (mag),
        .side_out (side_sq)
    );

    // ---- divider setup: numerator with half-divisor rounding ----
    logic [NumW-1:0]  num_reg [Lanes];
    logic [RootW-1:0] den_reg;
    tag_t             tag_reg [QW+1];

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < Lanes; k++) begin
                num_reg[k] <= {1'b0, side_sq.amag[k], 28'b0} + NumW'(mag >> 1);
            end
            den_reg    <= mag;
            tag_reg[0] <= '{neg: side_sq.neg, deg: side_sq.deg};
            for (int k = 1; k <= QW; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // ---- dividers, one per component ----
    logic [QW-1:0] quo [Lanes];

    for (genvar k = 0; k < Lanes; k++) begin : g_lane
        rmq_div u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[k]),
            .den (den_reg),
            .quo (quo[k])
        );
    end

    // ---- output register: sign restore and degenerate mask ----
    logic [QW-1:0] q_reg [Lanes];
    logic          deg_reg;
    tag_t          tag_out;

    // tag lined up with the last divider stage
    assign tag_out = tag_reg[QW];

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < Lanes; k++) begin
                if (tag_out.deg) begin
                    q_reg[k] <= '0;
                end else if (tag_out.neg[k]) begin
                    q_reg[k] <= -quo[k];
                end else begin
                    q_reg[k] <= quo[k];
                end
            end
            deg_reg <= tag_out.deg;
        end
    end

    assign out_valid  = vld_reg[NStg-1];
    assign qx         = q_reg[0];
    assign qy         = q_reg[1];
    assign qz         = q_reg[2];
    assign qw         = q_reg[3];
    assign degenerate = deg_reg;

    // a unit quaternion always has a component of at least one half
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> (qx != 0 || qy != 0 || qz != 0 || qw != 0))
        else $error("normal result with all components zero");

    // a stalled output freezes every stage's valid bit
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    // an accepted beat lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

    // degenerate results carry zero components
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> (qx == 0 && qy == 0 && qz == 0 && qw == 0))
        else $error("degenerate result with nonzero component");

endmodule
